>>> hdl/mg_rk4_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mg_rk4_pkg
// Shared types, constants and fixed-point helpers of the Mackey-Glass
// fourth-order Runge-Kutta generator.
// ----------------------------------------------------------------------------
package mg_rk4_pkg;

    localparam int MAX_DELAY_DEF = 32;
    localparam int FRAC_BITS_DEF = 28;

    localparam logic [30:0] START_RST = 31'd26843546;
    localparam logic [5:0]  DELAY_RST = 6'd17;
    localparam logic [30:0] GAIN_RST  = 31'd53687091;
    localparam logic [30:0] DECAY_RST = 31'd26843546;
    localparam logic [4:0]  EXP_RST   = 5'd10;

    localparam logic signed [31:0] Q_MAX   = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q_MIN   = 32'sh8000_0000;
    // ceil(2^33 / 3): exact floor division by three for operands below 2^33.
    localparam logic [31:0]        RECIP_THREE = 32'hAAAA_AAAB;

    typedef enum logic [2:0] {
        REG_START = 3'd0,
        REG_DELAY = 3'd1,
        REG_GAIN  = 3'd2,
        REG_DECAY = 3'd3,
        REG_EXP   = 3'd4
    } reg_idx_t;

    typedef enum logic [4:0] {
        ST_IDLE, ST_FILL, ST_MODPOS, ST_RD0, ST_RD1, ST_XM,
        ST_PW_INIT, ST_PW_MUL, ST_PW_RND, ST_NUM_MUL, ST_NUM_RND,
        ST_DIV_GO, ST_DIV_WAIT, ST_K_MUL, ST_K_RND, ST_K_SUB, ST_K_Y,
        ST_FIN, ST_FIN_WAIT, ST_FIN_ADD, ST_WB
    } state_t;

    typedef struct packed {
        logic               clip;
        logic signed [31:0] val;
    } sat_t;

    typedef struct packed {
        logic               done;
        logic               ovf;
        logic signed [31:0] quot;
    } div_res_t;

    function automatic sat_t sat32(input logic signed [63:0] v);
        sat_t r;
        if (v > 64'sd2147483647) begin
            r.clip = 1'b1;
            r.val  = Q_MAX;
        end else if (v < -64'sd2147483648) begin
            r.clip = 1'b1;
            r.val  = Q_MIN;
        end else begin
            r.clip = 1'b0;
            r.val  = v[31:0];
        end
        return r;
    endfunction

    // Round half up, then drop the fraction bits with a floor shift.
    function automatic sat_t qround(input logic signed [63:0] p, input int unsigned frac);
        logic signed [63:0] t;
        t = (p + (64'sd1 <<< (frac - 1))) >>> frac;
        return sat32(t);
    endfunction

endpackage
`default_nettype wire

>>> hdl/mackey_glass_rk4_generator_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mackey_glass_rk4_generator_unit
// Mackey-Glass series generator, one RK4 step of size 1 per request.
// ----------------------------------------------------------------------------
// Each request on the input stream yields one sample on the output stream.
// A restart request (and the first request after reset) writes the start
// value into all MAX_DELAY ring entries, one per cycle, and returns it. A
// step request reduces the ring position by subtracting the delay while it
// lies at or above it, reads the two delayed samples, then evaluates the
// delayed term three times on one shared multiplier and one bit-serial
// divider (the divider is skipped when the denominator is zero). The four
// slopes follow, then the final division by six, done by a reciprocal
// multiplication, and the write-back. One request is worked on at a time;
// the next one is taken once the output register is empty or is being
// emptied in the same cycle.
module mackey_glass_rk4_generator_unit #(
    parameter int MAX_DELAY = mg_rk4_pkg::MAX_DELAY_DEF,
    parameter int FRAC_BITS = mg_rk4_pkg::FRAC_BITS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [7:0]  s_tdata,   // [0] restart, [7:1] zero
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // [31:0] sample
    output logic [0:0]       m_tuser,   // [0] saturated
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam int AW = $clog2(MAX_DELAY);
    localparam int CW = $clog2(MAX_DELAY + 1);
    localparam int DW = 32 + FRAC_BITS;
    localparam logic signed [31:0] ONE_Q = 32'sd1 <<< FRAC_BITS;

    typedef mg_rk4_pkg::state_t state_t;
    typedef mg_rk4_pkg::sat_t   sat_t;

    // Configuration
    logic [30:0] start_reg, gain_reg, decay_reg;
    logic [5:0]  delay_reg;
    logic [4:0]  exp_reg;
    logic        cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= mg_rk4_pkg::START_RST;
            delay_reg <= mg_rk4_pkg::DELAY_RST;
            gain_reg  <= mg_rk4_pkg::GAIN_RST;
            decay_reg <= mg_rk4_pkg::DECAY_RST;
            exp_reg   <= mg_rk4_pkg::EXP_RST;
        end else if (cfg_we) begin
            unique case (paddr[4:2])
                mg_rk4_pkg::REG_START: start_reg <= pwdata[30:0];
                mg_rk4_pkg::REG_DELAY: delay_reg <= pwdata[5:0];
                mg_rk4_pkg::REG_GAIN:  gain_reg  <= pwdata[30:0];
                mg_rk4_pkg::REG_DECAY: decay_reg <= pwdata[30:0];
                mg_rk4_pkg::REG_EXP:   exp_reg   <= pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            mg_rk4_pkg::REG_START: prdata = {1'b0, start_reg};
            mg_rk4_pkg::REG_DELAY: prdata = {26'd0, delay_reg};
            mg_rk4_pkg::REG_GAIN:  prdata = {1'b0, gain_reg};
            mg_rk4_pkg::REG_DECAY: prdata = {1'b0, decay_reg};
            mg_rk4_pkg::REG_EXP:   prdata = {27'd0, exp_reg};
            default:               prdata = '0;
        endcase
    end

    // Effective delay, clamped to 1..MAX_DELAY.
    logic [CW-1:0] d_cur;
    always_comb begin
        if (delay_reg == 6'd0) begin
            d_cur = CW'(1);
        end else if ({26'd0, delay_reg} > 32'(MAX_DELAY)) begin
            d_cur = CW'(MAX_DELAY);
        end else begin
            d_cur = CW'(delay_reg);
        end
    end

    // Sequencer registers
    state_t             state_reg, state_next;
    logic               primed_reg, primed_next;
    logic [AW-1:0]      pos_reg, pos_next;
    logic [AW-1:0]      nxt_reg, nxt_next;
    logic [AW-1:0]      fill_reg, fill_next;
    logic signed [31:0] x_reg, x_next;
    logic signed [31:0] xo_reg, xo_next, xe_reg, xe_next, xm_reg, xm_next;
    logic [1:0]         term_reg, term_next;
    logic signed [31:0] pw_reg, pw_next;
    logic [4:0]         cnt_reg, cnt_next;
    logic signed [31:0] den_reg, den_next, num_reg, num_next;
    logic signed [31:0] qo_reg, qo_next, qm_reg, qm_next, qe_reg, qe_next;
    logic signed [31:0] g_reg, g_next, k_reg, k_next, y_reg, y_next, xn_reg, xn_next;
    logic [1:0]         kidx_reg, kidx_next;
    logic signed [34:0] sum_reg, sum_next;
    logic [48:0]        phi_reg, phi_next;
    logic signed [32:0] q6_reg, q6_next;
    logic               clip_reg, clip_next;
    logic               mval_reg, mval_next;
    logic signed [31:0] msample_reg, msample_next;
    logic               msat_reg, msat_next;
    logic signed [63:0] prod_reg;

    // Datapath helpers
    logic signed [31:0] mul_a, mul_b, xd, qsel, term_q;
    logic               term_store;
    logic [CW-1:0]      pos1;
    sat_t               rq, sq;
    logic               s_accept;
    logic [34:0]        sum_mag;
    logic [32:0]        half_mag;
    logic [47:0]        plo;
    logic [64:0]        q3_full;
    logic [31:0]        q3;

    // Ring and divider links
    logic                 ring_we;
    logic [AW-1:0]        ring_waddr, ring_raddr;
    logic [31:0]          ring_wdata, ring_rdata;
    logic                 div_start;
    logic signed [DW-1:0] div_dividend;
    logic signed [31:0]   div_divisor;
    mg_rk4_pkg::div_res_t div_res;

    assign s_tready = (state_reg == mg_rk4_pkg::ST_IDLE) && (!mval_reg || m_tready);
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = mval_reg;
    assign m_tdata  = msample_reg;
    assign m_tuser  = msat_reg;

    // Sum / 6 truncated toward zero: halve the magnitude, then divide by three
    // with a reciprocal product split into a high and a low half.
    assign sum_mag  = sum_reg[34] ? 35'(-sum_reg) : 35'(sum_reg);
    assign half_mag = sum_mag[33:1];
    assign plo      = 48'(half_mag[15:0]) * 48'(mg_rk4_pkg::RECIP_THREE);
    assign q3_full  = {phi_reg, 16'd0} + 65'(plo);
    assign q3       = q3_full[64:33];

    always_comb begin
        unique case (term_reg)
            2'd0:    xd = xo_reg;
            2'd1:    xd = xm_reg;
            default: xd = xe_reg;
        endcase
        unique case (kidx_reg)
            2'd0:    qsel = qo_reg;
            2'd3:    qsel = qe_reg;
            default: qsel = qm_reg;
        endcase
        priority case (state_reg)
            mg_rk4_pkg::ST_PW_MUL: begin
                mul_a = pw_reg;
                mul_b = xd;
            end
            mg_rk4_pkg::ST_NUM_MUL: begin
                mul_a = {1'b0, gain_reg};
                mul_b = xd;
            end
            default: begin
                mul_a = {1'b0, decay_reg};
                mul_b = y_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
    end

    assign rq         = mg_rk4_pkg::qround(prod_reg, FRAC_BITS);
    assign ring_raddr = (state_reg == mg_rk4_pkg::ST_MODPOS) ? pos_reg : nxt_reg;
    assign pos1       = CW'(pos_reg) + CW'(1);

    always_comb begin
        state_next   = state_reg;
        primed_next  = primed_reg;
        pos_next     = pos_reg;
        nxt_next     = nxt_reg;
        fill_next    = fill_reg;
        x_next       = x_reg;
        xo_next      = xo_reg;
        xe_next      = xe_reg;
        xm_next      = xm_reg;
        term_next    = term_reg;
        pw_next      = pw_reg;
        cnt_next     = cnt_reg;
        den_next     = den_reg;
        num_next     = num_reg;
        qo_next      = qo_reg;
        qm_next      = qm_reg;
        qe_next      = qe_reg;
        g_next       = g_reg;
        k_next       = k_reg;
        y_next       = y_reg;
        xn_next      = xn_reg;
        kidx_next    = kidx_reg;
        sum_next     = sum_reg;
        phi_next     = phi_reg;
        q6_next      = q6_reg;
        clip_next    = clip_reg;
        mval_next    = mval_reg && !m_tready;
        msample_next = msample_reg;
        msat_next    = msat_reg;
        ring_we      = 1'b0;
        ring_waddr   = pos_reg;
        ring_wdata   = xn_reg;
        div_start    = 1'b0;
        div_dividend = {num_reg, {FRAC_BITS{1'b0}}};
        div_divisor  = den_reg;
        term_store   = 1'b0;
        term_q       = div_res.quot;
        sq           = mg_rk4_pkg::sat32(64'(x_reg) + 64'(q6_reg));

        unique case (state_reg)
            mg_rk4_pkg::ST_IDLE: begin
                if (s_accept) begin
                    clip_next = 1'b0;
                    if (s_tdata[0] || !primed_reg) begin
                        fill_next  = '0;
                        state_next = mg_rk4_pkg::ST_FILL;
                    end else begin
                        state_next = mg_rk4_pkg::ST_MODPOS;
                    end
                end
            end
            mg_rk4_pkg::ST_FILL: begin
                ring_we    = 1'b1;
                ring_waddr = fill_reg;
                ring_wdata = {1'b0, start_reg};
                fill_next  = fill_reg + 1'b1;
                if (fill_reg == AW'(MAX_DELAY - 1)) begin
                    pos_next     = '0;
                    x_next       = {1'b0, start_reg};
                    primed_next  = 1'b1;
                    mval_next    = 1'b1;
                    msample_next = {1'b0, start_reg};
                    msat_next    = 1'b0;
                    state_next   = mg_rk4_pkg::ST_IDLE;
                end
            end
            mg_rk4_pkg::ST_MODPOS: begin
                // Bring the position below a delay that shrank since the last step.
                if (CW'(pos_reg) >= d_cur) begin
                    pos_next = AW'(CW'(pos_reg) - d_cur);
                end else begin
                    nxt_next   = (pos1 == d_cur) ? '0 : AW'(pos1);
                    state_next = mg_rk4_pkg::ST_RD0;
                end
            end
            mg_rk4_pkg::ST_RD0: begin
                xo_next    = ring_rdata;
                state_next = mg_rk4_pkg::ST_RD1;
            end
            mg_rk4_pkg::ST_RD1: begin
                xe_next    = ring_rdata;
                state_next = mg_rk4_pkg::ST_XM;
            end
            mg_rk4_pkg::ST_XM: begin
                xm_next    = 32'((33'(xo_reg) + 33'(xe_reg)) >>> 1);
                term_next  = 2'd0;
                state_next = mg_rk4_pkg::ST_PW_INIT;
            end
            mg_rk4_pkg::ST_PW_INIT: begin
                pw_next    = ONE_Q;
                cnt_next   = '0;
                state_next = (exp_reg == 5'd0) ? mg_rk4_pkg::ST_NUM_MUL
                                               : mg_rk4_pkg::ST_PW_MUL;
            end
            mg_rk4_pkg::ST_PW_MUL: begin
                state_next = mg_rk4_pkg::ST_PW_RND;
            end
            mg_rk4_pkg::ST_PW_RND: begin
                pw_next   = rq.val;
                clip_next = clip_reg | rq.clip;
                cnt_next  = cnt_reg + 1'b1;
                state_next = (cnt_reg + 5'd1 == exp_reg) ? mg_rk4_pkg::ST_NUM_MUL
                                                         : mg_rk4_pkg::ST_PW_MUL;
            end
            mg_rk4_pkg::ST_NUM_MUL: begin
                sq         = mg_rk4_pkg::sat32(64'(ONE_Q) + 64'(pw_reg));
                den_next   = sq.val;
                clip_next  = clip_reg | sq.clip;
                state_next = mg_rk4_pkg::ST_NUM_RND;
            end
            mg_rk4_pkg::ST_NUM_RND: begin
                num_next   = rq.val;
                clip_next  = clip_reg | rq.clip;
                state_next = mg_rk4_pkg::ST_DIV_GO;
            end
            mg_rk4_pkg::ST_DIV_GO: begin
                if (den_reg == 32'sd0) begin
                    // A zero denominator saturates toward the numerator's sign.
                    term_store = 1'b1;
                    if (num_reg == 32'sd0) begin
                        term_q = 32'sd0;
                    end else begin
                        term_q    = num_reg[31] ? mg_rk4_pkg::Q_MIN : mg_rk4_pkg::Q_MAX;
                        clip_next = 1'b1;
                    end
                end else begin
                    div_start  = 1'b1;
                    state_next = mg_rk4_pkg::ST_DIV_WAIT;
                end
            end
            mg_rk4_pkg::ST_DIV_WAIT: begin
                if (div_res.done) begin
                    term_store = 1'b1;
                    clip_next  = clip_reg | div_res.ovf;
                end
            end
            mg_rk4_pkg::ST_K_MUL: begin
                state_next = mg_rk4_pkg::ST_K_RND;
            end
            mg_rk4_pkg::ST_K_RND: begin
                g_next     = rq.val;
                clip_next  = clip_reg | rq.clip;
                state_next = mg_rk4_pkg::ST_K_SUB;
            end
            mg_rk4_pkg::ST_K_SUB: begin
                sq         = mg_rk4_pkg::sat32(64'(qsel) - 64'(g_reg));
                k_next     = sq.val;
                clip_next  = clip_reg | sq.clip;
                state_next = mg_rk4_pkg::ST_K_Y;
            end
            mg_rk4_pkg::ST_K_Y: begin
                if (kidx_reg == 2'd1 || kidx_reg == 2'd2) begin
                    sum_next = sum_reg + {k_reg[31], k_reg[31], k_reg, 1'b0};
                end else begin
                    sum_next = sum_reg + 35'(k_reg);
                end
                if (kidx_reg == 2'd2) begin
                    sq = mg_rk4_pkg::sat32(64'(x_reg) + 64'(k_reg));
                end else begin
                    sq = mg_rk4_pkg::sat32(64'(x_reg) + 64'(k_reg >>> 1));
                end
                kidx_next = kidx_reg + 1'b1;
                if (kidx_reg == 2'd3) begin
                    state_next = mg_rk4_pkg::ST_FIN;
                end else begin
                    y_next     = sq.val;
                    clip_next  = clip_reg | sq.clip;
                    state_next = mg_rk4_pkg::ST_K_MUL;
                end
            end
            mg_rk4_pkg::ST_FIN: begin
                phi_next   = 49'(half_mag[32:16]) * 49'(mg_rk4_pkg::RECIP_THREE);
                state_next = mg_rk4_pkg::ST_FIN_WAIT;
            end
            mg_rk4_pkg::ST_FIN_WAIT: begin
                q6_next    = sum_reg[34] ? -$signed({1'b0, q3}) : $signed({1'b0, q3});
                state_next = mg_rk4_pkg::ST_FIN_ADD;
            end
            mg_rk4_pkg::ST_FIN_ADD: begin
                xn_next    = sq.val;
                clip_next  = clip_reg | sq.clip;
                state_next = mg_rk4_pkg::ST_WB;
            end
            mg_rk4_pkg::ST_WB: begin
                ring_we      = 1'b1;
                x_next       = xn_reg;
                pos_next     = nxt_reg;
                mval_next    = 1'b1;
                msample_next = xn_reg;
                msat_next    = clip_reg;
                state_next   = mg_rk4_pkg::ST_IDLE;
            end
            default: state_next = mg_rk4_pkg::ST_IDLE;
        endcase

        if (term_store) begin
            unique case (term_reg)
                2'd0:    qo_next = term_q;
                2'd1:    qm_next = term_q;
                default: qe_next = term_q;
            endcase
            if (term_reg == 2'd2) begin
                y_next     = x_reg;
                kidx_next  = 2'd0;
                sum_next   = '0;
                state_next = mg_rk4_pkg::ST_K_MUL;
            end else begin
                term_next  = term_reg + 1'b1;
                state_next = mg_rk4_pkg::ST_PW_INIT;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= mg_rk4_pkg::ST_IDLE;
            primed_reg <= 1'b0;
            pos_reg    <= '0;
            x_reg      <= '0;
            mval_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            primed_reg <= primed_next;
            pos_reg    <= pos_next;
            x_reg      <= x_next;
            mval_reg   <= mval_next;
        end
        nxt_reg     <= nxt_next;
        fill_reg    <= fill_next;
        xo_reg      <= xo_next;
        xe_reg      <= xe_next;
        xm_reg      <= xm_next;
        term_reg    <= term_next;
        pw_reg      <= pw_next;
        cnt_reg     <= cnt_next;
        den_reg     <= den_next;
        num_reg     <= num_next;
        qo_reg      <= qo_next;
        qm_reg      <= qm_next;
        qe_reg      <= qe_next;
        g_reg       <= g_next;
        k_reg       <= k_next;
        y_reg       <= y_next;
        xn_reg      <= xn_next;
        kidx_reg    <= kidx_next;
        sum_reg     <= sum_next;
        phi_reg     <= phi_next;
        q6_reg      <= q6_next;
        clip_reg    <= clip_next;
        msample_reg <= msample_next;
        msat_reg    <= msat_next;
    end

    mg_rk4_ring #(
        .DEPTH (MAX_DELAY),
        .AW    (AW)
    ) u_ring (
        .aclk  (aclk),
        .we    (ring_we),
        .waddr (ring_waddr),
        .wdata (ring_wdata),
        .raddr (ring_raddr),
        .rdata (ring_rdata)
    );

    mg_rk4_div #(
        .DW (DW)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .res      (div_res)
    );

`ifndef SYNTHESIS
    // The ring is read only after the position has been brought below the delay.
    a_pos_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mg_rk4_pkg::ST_RD0) |-> (CW'(pos_reg) < d_cur))
        else $error("ring position not reduced below delay");

    a_nxt_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == mg_rk4_pkg::ST_RD1) |-> (CW'(nxt_reg) < d_cur))
        else $error("endpoint index beyond delay");

    a_div_done_waited: assert property (@(posedge aclk) disable iff (!aresetn)
        div_res.done |-> (state_reg == mg_rk4_pkg::ST_DIV_WAIT))
        else $error("divider finished outside a wait state");

    a_out_primed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> primed_reg)
        else $error("sample emitted before the ring was filled");

    a_accept_leaves_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        s_accept |=> (state_reg != mg_rk4_pkg::ST_IDLE))
        else $error("request accepted without starting work");
`endif

endmodule
`default_nettype wire

>>> hdl/mg_rk4_ring.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mg_rk4_ring
// Delay-line storage: one write port and one read port with registered data.
// ----------------------------------------------------------------------------
module mg_rk4_ring #(
    parameter int DEPTH = mg_rk4_pkg::MAX_DELAY_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic          aclk,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [31:0]   wdata,
    input  wire logic [AW-1:0] raddr,
    output logic [31:0]        rdata
);

    logic [31:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

>>> hdl/mg_rk4_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mg_rk4_div
// Signed restoring divider, one quotient bit per cycle, quotient truncated
// toward zero and saturated to 32 bits.
// ----------------------------------------------------------------------------
module mg_rk4_div #(
    parameter int DW = 60
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 start,
    input  wire logic signed [DW-1:0] dividend,
    input  wire logic signed [31:0]   divisor,
    output mg_rk4_pkg::div_res_t      res
);

    localparam int CNTW = $clog2(DW + 1);

    logic            busy_reg, busy_next;
    logic            done_reg, done_next;
    logic [CNTW-1:0] cnt_reg, cnt_next;
    logic [DW-1:0]   quo_reg, quo_next;
    logic [32:0]     rem_reg, rem_next;
    logic [31:0]     dmag_reg, dmag_next;
    logic            neg_reg, neg_next;
    logic [32:0]     rem_sh;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dmag_next = dmag_reg;
        neg_next  = neg_reg;
        rem_sh    = {rem_reg[31:0], quo_reg[DW-1]};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
            dmag_next = divisor[31] ? 32'(-divisor) : 32'(divisor);
            neg_next  = dividend[DW-1] ^ divisor[31];
        end else if (busy_reg) begin
            if (rem_sh >= {1'b0, dmag_reg}) begin
                rem_next = rem_sh - {1'b0, dmag_reg};
                quo_next = {quo_reg[DW-2:0], 1'b1};
            end else begin
                rem_next = rem_sh;
                quo_next = {quo_reg[DW-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNTW'(DW - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
        cnt_reg  <= cnt_next;
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        dmag_reg <= dmag_next;
        neg_reg  <= neg_next;
    end

    always_comb begin
        res.done = done_reg;
        res.ovf  = 1'b0;
        if (neg_reg) begin
            if (quo_reg > DW'(32'h8000_0000)) begin
                res.ovf  = 1'b1;
                res.quot = mg_rk4_pkg::Q_MIN;
            end else begin
                res.quot = 32'(~quo_reg[31:0] + 32'd1);
            end
        end else begin
            if (quo_reg > DW'(32'h7FFF_FFFF)) begin
                res.ovf  = 1'b1;
                res.quot = mg_rk4_pkg::Q_MAX;
            end else begin
                res.quot = quo_reg[31:0];
            end
        end
    end

endmodule
`default_nettype wire
